// ===== rtl/core/pcds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcds_pkg
// Shared types, codes and reset values of the phase-cut dimmer scheduler.
// ----------------------------------------------------------------------------
package pcds_pkg;

	localparam int DELAY_W        = 10;
	localparam int CMD_W          = 2;
	localparam int CHAN_W         = 2;
	localparam int VALUE_W        = 8;
	localparam int GATE_W         = 4;
	localparam int REG_IDX_W      = 2;
	localparam int DEFAULT_CHANNELS = 4;

	localparam logic [DELAY_W-1:0] RST_PERIOD_TOP   = 10'd625;
	localparam logic [DELAY_W-1:0] RST_RESYNC_COUNT = 10'd620;
	localparam logic [DELAY_W-1:0] RST_OFF_POINT    = 10'd550;
	localparam logic [DELAY_W-1:0] DELAY_BASE       = 10'd512;
	localparam logic [VALUE_W-1:0] BRIGHT_FULL      = 8'd255;
	localparam logic [VALUE_W-1:0] BRIGHT_NONE      = 8'd0;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK       = 2'd0,
		CMD_ZERO_CROSS = 2'd1,
		CMD_SET_LEVEL  = 2'd2,
		CMD_SET_ENABLE = 2'd3
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PERIOD_TOP   = 2'd0,
		REG_RESYNC_COUNT = 2'd1,
		REG_OFF_POINT    = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PLACE
	} state_t;

	// Operation broadcast to every cell of the table row.
	typedef struct packed {
		logic               remove;
		logic               place;
		logic               latch;
		logic               fire_en;
		logic [DELAY_W-1:0] new_delay;
		logic [DELAY_W-1:0] tick;
		logic [DELAY_W-1:0] off_point;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/pcds_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcds_cell
// One slot of the sorted firing table: pending and latched entry, with the
// neighbor links used for remove, sorted insert and chained firing.
// ----------------------------------------------------------------------------
module pcds_cell #(
	parameter int OW   = 2,
	parameter int IDX  = 0,
	parameter bit LAST = 1'b0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcds_pkg::cell_ctrl_t          ctrl,
	input  logic [OW-1:0]                 chan,
	input  logic                          slot_hit,
	input  logic [OW-1:0]                 left_ord,
	input  logic [pcds_pkg::DELAY_W-1:0]  left_del,
	input  logic [OW-1:0]                 right_ord,
	input  logic [pcds_pkg::DELAY_W-1:0]  right_del,
	input  logic                          rm_in,
	output logic                          rm_out,
	input  logic                          ins_in,
	output logic                          ins_out,
	input  logic                          run_in,
	output logic                          run_out,
	output logic [OW-1:0]                 pend_ord,
	output logic [pcds_pkg::DELAY_W-1:0]  pend_del,
	output logic [OW-1:0]                 lat_ord,
	output logic                          fire,
	output logic                          stop,
	output logic                          never
);

	logic [OW-1:0]                pord_q;
	logic [pcds_pkg::DELAY_W-1:0] pdel_q;
	logic [OW-1:0]                lord_q;
	logic [pcds_pkg::DELAY_W-1:0] ldel_q;
	logic                         found;
	logic                         gt;
	logic                         armed;

	assign found   = rm_in | (pord_q == chan);
	assign rm_out  = found;
	assign gt      = LAST | (ctrl.new_delay < pdel_q);
	assign ins_out = ins_in | gt;

	// later slots join the firing run while their delay is already reached
	assign armed   = (ldel_q != ctrl.off_point) && (ctrl.tick >= ldel_q);
	assign fire    = ctrl.fire_en & ((slot_hit & (ctrl.tick == ldel_q)) | (run_in & armed));
	assign run_out = fire;
	assign stop    = run_in & ~fire;
	assign never   = (ldel_q == ctrl.off_point);

	assign pend_ord = pord_q;
	assign pend_del = pdel_q;
	assign lat_ord  = lord_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pord_q <= OW'(IDX);
			pdel_q <= pcds_pkg::RST_OFF_POINT;
			lord_q <= OW'(IDX);
			ldel_q <= pcds_pkg::RST_OFF_POINT;
		end else begin
			if (ctrl.remove && found) begin
				pord_q <= right_ord;
				pdel_q <= right_del;
			end else if (ctrl.place) begin
				if (ins_in) begin
					pord_q <= left_ord;
					pdel_q <= left_del;
				end else if (gt) begin
					pord_q <= chan;
					pdel_q <= ctrl.new_delay;
				end
			end
			if (ctrl.latch) begin
				lord_q <= pord_q;
				ldel_q <= pdel_q;
			end
		end
	end

endmodule

// ===== rtl/core/phase_cut_dimmer_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_cut_dimmer_scheduler
// Multi-channel mains phase-cut dimmer with a sorted firing table.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries commands: tuser = command (tick, zero-cross, set
//   brightness, set enable), tdata = channel and value. Every command yields
//   one result on m_*: the four gate levels and the zero-cross extra gate.
//   cfg_* writes period_top (0), resync_count (1), off_point (2) while idle; user's duty, unchecked.
// Timing:
//   A command is taken into an input register at the accepting edge. Ticks,
//   zero-crosses and enables reach execution in the next cycle; their result
//   is written to the output register and shown on m_tvalid once that register
//   is free. Set brightness first makes one remove pass over the cell row and
//   then one sorted insert pass, which writes its result. A new command is
//   taken only when the sequencer is idle again. The firing table is a row of
//   cells; chained firing of equal delays happens in a single pass.
// Reset:
//   arst_n clears all state but the command and result data registers to the
//   power-up values (off_point 550, table in channel order, none enabled, gates low).
// Stalls:
//   With m_tready low the result holds in the output register; one more
//   command can be accepted and waits in execution until the register frees.
// ----------------------------------------------------------------------------
module phase_cut_dimmer_scheduler #(
	parameter int CHANNELS = pcds_pkg::DEFAULT_CHANNELS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,   // [1:0] channel, [9:2] value
	input  logic [pcds_pkg::CMD_W-1:0]      s_tuser,   // [1:0] command
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // [3:0] gate_bits, [4] extra_gate
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pcds_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [pcds_pkg::DELAY_W-1:0]    cfg_data
);

	localparam int OW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW = $clog2(CHANNELS + 1);
	localparam int GC = (CHANNELS < pcds_pkg::GATE_W) ? CHANNELS : pcds_pkg::GATE_W;
	localparam int DW = pcds_pkg::DELAY_W;

	pcds_pkg::state_t state_q, state_d;

	logic [DW-1:0] period_q, resync_q, off_q;
	logic [DW-1:0] count_q, count_d, count_next;
	logic          phase_q, phase_d;
	logic [SW-1:0] slot_q, slot_d;
	logic [GC-1:0] gates_q, gates_d;
	logic [GC-1:0] aon_q, aon_d;
	logic [GC-1:0] en_q, en_d;
	logic          extra_q, extra_d;

	pcds_pkg::cmd_t              cmd_q;
	logic [pcds_pkg::CHAN_W-1:0] chan_q;
	logic [pcds_pkg::VALUE_W-1:0] val_q;

	logic                         m_tvalid_q;
	logic [pcds_pkg::GATE_W-1:0]  out_gates_q;
	logic                         out_extra_q;

	logic out_free, accept, do_remove, do_commit, ch_ok;
	logic tick_cmd, latch_now, fire_en, any_fire, any_stop, stop_never;
	logic [DW-1:0] new_delay;
	logic [SW-1:0] stop_idx;
	logic [GC-1:0] fire_ch;

	pcds_pkg::cell_ctrl_t ctrl;

	logic [OW-1:0] pord [CHANNELS];
	logic [DW-1:0] pdel [CHANNELS];
	logic [OW-1:0] lord [CHANNELS];
	logic [CHANNELS-1:0] fire_v, stop_v, never_v;
	logic [CHANNELS:0]   rm_c, ins_c, run_c;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= pcds_pkg::RST_PERIOD_TOP;
			resync_q <= pcds_pkg::RST_RESYNC_COUNT;
			off_q    <= pcds_pkg::RST_OFF_POINT;
		end else if (cfg_valid && cfg_ready) begin
			case (pcds_pkg::reg_idx_t'(cfg_index))
				pcds_pkg::REG_PERIOD_TOP:   period_q <= cfg_data;
				pcds_pkg::REG_RESYNC_COUNT: resync_q <= cfg_data;
				pcds_pkg::REG_OFF_POINT:    off_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------- sequencer
	assign out_free = ~m_tvalid_q | m_tready;
	assign accept   = s_tvalid & s_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pcds_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = pcds_pkg::ST_EXEC;
			end
			pcds_pkg::ST_EXEC: begin
				if (cmd_q == pcds_pkg::CMD_SET_LEVEL) state_d = pcds_pkg::ST_PLACE;
				else if (out_free)                    state_d = pcds_pkg::ST_IDLE;
			end
			pcds_pkg::ST_PLACE: begin
				if (out_free) state_d = pcds_pkg::ST_IDLE;
			end
			default: state_d = pcds_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		do_remove = 1'b0;
		do_commit = 1'b0;
		case (state_q)
			pcds_pkg::ST_IDLE: s_tready = 1'b1;
			pcds_pkg::ST_EXEC: begin
				if (cmd_q == pcds_pkg::CMD_SET_LEVEL) do_remove = 1'b1;
				else                                  do_commit = out_free;
			end
			pcds_pkg::ST_PLACE: do_commit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the accepted transaction for execution
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= pcds_pkg::cmd_t'(s_tuser);
			chan_q <= s_tdata[1:0];
			val_q  <= s_tdata[9:2];
		end
	end

	// ------------------------------------------------------------- cell row
	assign ch_ok      = (32'(chan_q) < CHANNELS);
	assign count_next = (count_q == period_q) ? '0 : count_q + 1'b1;
	assign new_delay  = ((val_q == pcds_pkg::BRIGHT_FULL) || (val_q == pcds_pkg::BRIGHT_NONE))
		? off_q : pcds_pkg::DELAY_BASE - DW'({val_q, 1'b0});

	assign tick_cmd  = do_commit & (cmd_q == pcds_pkg::CMD_TICK);
	assign latch_now = tick_cmd & ~phase_q & (count_next == off_q);
	assign fire_en   = tick_cmd & phase_q & (32'(slot_q) < CHANNELS);

	always_comb begin
		ctrl           = '0;
		ctrl.remove    = do_remove & ch_ok;
		ctrl.place     = do_commit & ch_ok & (cmd_q == pcds_pkg::CMD_SET_LEVEL);
		ctrl.latch     = latch_now;
		ctrl.fire_en   = fire_en;
		ctrl.new_delay = new_delay;
		ctrl.tick      = count_next;
		ctrl.off_point = off_q;
	end

	assign rm_c[0]  = 1'b0;
	assign ins_c[0] = 1'b0;
	assign run_c[0] = 1'b0;

	for (genvar j = 0; j < CHANNELS; j++) begin : g_cell
		localparam int LJ = (j > 0) ? j - 1 : 0;
		localparam int RJ = (j < CHANNELS - 1) ? j + 1 : j;
		pcds_cell #(
			.OW   (OW),
			.IDX  (j),
			.LAST (j == CHANNELS - 1)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.chan      (OW'(chan_q)),
			.slot_hit  (slot_q == SW'(j)),
			.left_ord  (pord[LJ]),
			.left_del  (pdel[LJ]),
			.right_ord (pord[RJ]),
			.right_del (pdel[RJ]),
			.rm_in     (rm_c[j]),
			.rm_out    (rm_c[j+1]),
			.ins_in    (ins_c[j]),
			.ins_out   (ins_c[j+1]),
			.run_in    (run_c[j]),
			.run_out   (run_c[j+1]),
			.pend_ord  (pord[j]),
			.pend_del  (pdel[j]),
			.lat_ord   (lord[j]),
			.fire      (fire_v[j]),
			.stop      (stop_v[j]),
			.never     (never_v[j])
		);
	end

	// collect fired slots per channel and find where the firing run ended
	always_comb begin
		fire_ch    = '0;
		stop_idx   = SW'(CHANNELS);
		stop_never = 1'b0;
		for (int j = 0; j < CHANNELS; j++) begin
			for (int k = 0; k < GC; k++) begin
				if (fire_v[j] && (lord[j] == OW'(k))) fire_ch[k] = 1'b1;
			end
			if (stop_v[j]) begin
				stop_idx   = SW'(j);
				stop_never = never_v[j];
			end
		end
	end

	assign any_fire = |fire_v;
	assign any_stop = |stop_v;

	// ---------------------------------------------------------- state update
	always_comb begin
		count_d = count_q;
		phase_d = phase_q;
		slot_d  = slot_q;
		gates_d = gates_q;
		aon_d   = aon_q;
		en_d    = en_q;
		extra_d = extra_q;
		case (cmd_q)
			pcds_pkg::CMD_TICK: begin
				count_d = count_next;
				if (!phase_q) begin
					if (latch_now) begin
						gates_d = gates_q & aon_q;
						slot_d  = '0;
						phase_d = (pdel[0] != off_q);
					end
				end else if (32'(slot_q) >= CHANNELS) begin
					phase_d = 1'b0;
				end else if (any_fire) begin
					gates_d = gates_q | (fire_ch & en_q);
					slot_d  = stop_idx;
					phase_d = any_stop & ~stop_never;
				end
			end
			pcds_pkg::CMD_ZERO_CROSS: begin
				count_d = resync_q;
				if ((GC == pcds_pkg::GATE_W) && en_q[GC-1]) extra_d = 1'b1;
			end
			pcds_pkg::CMD_SET_LEVEL: begin
				for (int k = 0; k < GC; k++) begin
					if (chan_q == pcds_pkg::CHAN_W'(k)) begin
						if (val_q == pcds_pkg::BRIGHT_FULL) begin
							aon_d[k] = 1'b1;
							if (en_q[k]) gates_d[k] = 1'b1;
						end else begin
							aon_d[k] = 1'b0;
						end
					end
				end
			end
			pcds_pkg::CMD_SET_ENABLE: begin
				for (int k = 0; k < GC; k++) begin
					if (chan_q == pcds_pkg::CHAN_W'(k)) begin
						en_d[k] = (val_q != '0);
						if (val_q != '0) begin
							if (aon_q[k]) gates_d[k] = 1'b1;
						end else if (k == pcds_pkg::GATE_W - 1) begin
							extra_d = 1'b0;
						end else begin
							gates_d[k] = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= 1'b0;
			slot_q  <= '0;
			gates_q <= '0;
			aon_q   <= '0;
			en_q    <= '0;
			extra_q <= 1'b0;
		end else if (do_commit) begin
			count_q <= count_d;
			phase_q <= phase_d;
			slot_q  <= slot_d;
			gates_q <= gates_d;
			aon_q   <= aon_d;
			en_q    <= en_d;
			extra_q <= extra_d;
		end
	end

	// ------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (do_commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_commit) begin
			out_gates_q <= pcds_pkg::GATE_W'(gates_d);
			out_extra_q <= extra_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_extra_q, out_gates_q};

	// ------------------------------------------------------------ assertions
	a_single_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(stop_v))
		else $error("firing run ended at more than one slot");

	a_slot_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (32'(slot_q) < CHANNELS))
		else $error("firing phase with slot past the table");

	a_place_after_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcds_pkg::ST_PLACE && $past(state_q) != pcds_pkg::ST_PLACE)
		|-> $past(state_q == pcds_pkg::ST_EXEC && cmd_q == pcds_pkg::CMD_SET_LEVEL))
		else $error("insert pass without a preceding remove pass");

	a_commit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		do_commit |-> (!m_tvalid_q || m_tready))
		else $error("result written over an unread result");

endmodule
